[hdl/lru_pr_pkg.sv]
// Shared types and constants for the LRU page replacement unit.
// No dependencies; every other file of the block imports this package.
package lru_pr_pkg;

    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 5;
    localparam int COUNT_W = 16;

    localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX           = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } lru_state_t;

    // Running search result that moves one cell per cycle along the chain.
    typedef struct packed {
        logic hit_found;
        logic empty_found;
    } scan_flags_t;

    // Update command broadcast to every cell at the end of an item.
    typedef struct packed {
        logic apply;
        logic fault;
        logic age_all;
        logic clear;
    } upd_ctl_t;

endpackage

[hdl/lru_pr_ifs.sv]
// Channel interfaces of the LRU page replacement unit: request, response, config.
// Depends on lru_pr_pkg for the payload widths.
interface lru_pr_req_if import lru_pr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page;
    logic              last_ref;

    modport source (output valid, output page, output last_ref, input ready);
    modport sink   (input valid, input page, input last_ref, output ready);
endinterface

interface lru_pr_rsp_if import lru_pr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
    logic               last_out;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_page, output fault_count, output last_out,
                    input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_page, input fault_count, input last_out,
                    output ready);
endinterface

interface lru_pr_cfg_if import lru_pr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/lru_pr_cell.sv]
// One page frame of the LRU unit: page, valid bit, age and one stage of the search chain.
// Depends on lru_pr_pkg.
module lru_pr_cell import lru_pr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int IDX       = 0,
    localparam int SW       = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int NW       = $clog2(FRAMES + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [NW-1:0]        n_in_use,
    input  logic [PAGE_BITS-1:0] query_page,
    input  scan_flags_t          flags_in,
    input  logic [SW-1:0]        hit_slot_in,
    input  logic [SW-1:0]        hit_rank_in,
    input  logic [SW-1:0]        empty_slot_in,
    input  logic [SW-1:0]        max_slot_in,
    input  logic [SW-1:0]        max_rank_in,
    input  logic [PAGE_BITS-1:0] max_page_in,
    output scan_flags_t          flags_out,
    output logic [SW-1:0]        hit_slot_out,
    output logic [SW-1:0]        hit_rank_out,
    output logic [SW-1:0]        empty_slot_out,
    output logic [SW-1:0]        max_slot_out,
    output logic [SW-1:0]        max_rank_out,
    output logic [PAGE_BITS-1:0] max_page_out,
    input  upd_ctl_t             upd,
    input  logic [SW-1:0]        upd_slot,
    input  logic [SW-1:0]        upd_limit
);

    localparam logic [NW-1:0] IDX_N = NW'(IDX);
    localparam logic [SW-1:0] IDX_S = SW'(IDX);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg, valid_next;
    logic [SW-1:0]        rank_reg, rank_next;

    scan_flags_t          flags_reg, flags_next;
    logic [SW-1:0]        hit_slot_reg, hit_slot_next;
    logic [SW-1:0]        hit_rank_reg, hit_rank_next;
    logic [SW-1:0]        empty_slot_reg, empty_slot_next;
    logic [SW-1:0]        max_slot_reg, max_slot_next;
    logic [SW-1:0]        max_rank_reg, max_rank_next;
    logic [PAGE_BITS-1:0] max_page_reg, max_page_next;

    logic in_use;
    logic selected;
    logic page_write;

    assign in_use     = IDX_N < n_in_use;
    assign selected   = upd_slot == IDX_S;
    assign page_write = upd.apply && upd.fault && selected && !upd.clear;

    // Search stage: fold this frame into the result handed on by the lower neighbor.
    always_comb
    begin
        flags_next      = flags_in;
        hit_slot_next   = hit_slot_in;
        hit_rank_next   = hit_rank_in;
        empty_slot_next = empty_slot_in;
        max_slot_next   = max_slot_in;
        max_rank_next   = max_rank_in;
        max_page_next   = max_page_in;
        if (in_use && valid_reg && page_reg == query_page && !flags_in.hit_found)
        begin
            flags_next.hit_found = 1'b1;
            hit_slot_next        = IDX_S;
            hit_rank_next        = rank_reg;
        end
        // The highest empty frame wins because later cells overwrite.
        if (in_use && !valid_reg)
        begin
            flags_next.empty_found = 1'b1;
            empty_slot_next        = IDX_S;
        end
        // Frame zero seeds the oldest-frame search; later frames replace it only if older.
        if (IDX == 0 || (in_use && rank_reg > max_rank_in))
        begin
            max_slot_next = IDX_S;
            max_rank_next = rank_reg;
            max_page_next = page_reg;
        end
    end

    // Update: touched frame -> youngest, younger valid frames age by one; clear empties all.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.clear)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        else if (upd.apply)
        begin
            if (selected)
            begin
                rank_next = '0;
                if (upd.fault)
                begin
                    valid_next = 1'b1;
                end
            end
            else if (valid_reg && (upd.age_all || rank_reg < upd_limit))
            begin
                rank_next = rank_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (page_write)
        begin
            page_reg <= query_page;
        end
        hit_slot_reg   <= hit_slot_next;
        hit_rank_reg   <= hit_rank_next;
        empty_slot_reg <= empty_slot_next;
        max_slot_reg   <= max_slot_next;
        max_rank_reg   <= max_rank_next;
        max_page_reg   <= max_page_next;
    end

    assign flags_out      = flags_reg;
    assign hit_slot_out   = hit_slot_reg;
    assign hit_rank_out   = hit_rank_reg;
    assign empty_slot_out = empty_slot_reg;
    assign max_slot_out   = max_slot_reg;
    assign max_rank_out   = max_rank_reg;
    assign max_page_out   = max_page_reg;

endmodule

[hdl/lru_page_replacement_unit.sv]
// Top level of the LRU page replacement unit: control, fault counter, output register.
// Depends on lru_pr_pkg, lru_pr_ifs and lru_pr_cell.
//
// Usage: each request transfer on req carries one page reference and a last_ref
// flag. The unit searches the frames in use for the page, updates the true-LRU
// ages and returns one response on rsp: hit or fault, the slot that now holds the
// page, the evicted page if a resident page was replaced, and the saturating fault
// count. A response with last_out set ends a reference string; after it all frames
// are empty and the fault count is zero.
// The search runs as a wave through a chain of FRAMES cells, one cell per cycle. Each
// reference passes through the accept, search and update steps before the next
// request is taken; the response register is loaded in the update step.
// One reference is in flight at a time.
// The cfg channel, always ready, writes frames_in_use (0 acts as 1, above FRAMES acts
// as FRAMES). Write it only while the unit is idle; the unit does not enforce this.
// Reset empties every frame, clears the fault count and sets frames_in_use to 16.
// A stalled response waits in the output register while the next request is taken;
// the unit holds in its update step until that register is free.
module lru_page_replacement_unit import lru_pr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    lru_pr_req_if.sink   req,
    lru_pr_rsp_if.source rsp,
    lru_pr_cfg_if.sink   cfg
);

    localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW = $clog2(FRAMES + 1);
    localparam logic [SW-1:0] CNT_LAST = SW'(FRAMES - 1);

    lru_state_t           state_reg, state_next;
    logic [SW-1:0]        cnt_reg, cnt_next;
    logic [CFG_W-1:0]     frames_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 last_reg;
    logic [COUNT_W-1:0]   fault_reg, fault_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_ev_valid_reg;
    logic [PAGE_W-1:0]    out_ev_page_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_last_reg;

    logic [NW-1:0]                 n_eff;
    logic [PAGE_W+PAGE_BITS-1:0]   page_in_wide;
    logic [PAGE_BITS+PAGE_W-1:0]   ev_page_wide;
    logic [SLOT_W+SW-1:0]          slot_wide;
    logic                          req_xfer;
    logic                          load_out;
    upd_ctl_t                      upd;
    logic [SW-1:0]                 upd_limit;
    logic [SW-1:0]                 sel_slot;
    logic                          res_hit;
    logic                          res_ev_valid;
    logic [COUNT_W-1:0]            count_new;

    scan_flags_t          chain_flags      [FRAMES+1];
    logic [SW-1:0]        chain_hit_slot   [FRAMES+1];
    logic [SW-1:0]        chain_hit_rank   [FRAMES+1];
    logic [SW-1:0]        chain_empty_slot [FRAMES+1];
    logic [SW-1:0]        chain_max_slot   [FRAMES+1];
    logic [SW-1:0]        chain_max_rank   [FRAMES+1];
    logic [PAGE_BITS-1:0] chain_max_page   [FRAMES+1];

    assign chain_flags[0]      = '0;
    assign chain_hit_slot[0]   = '0;
    assign chain_hit_rank[0]   = '0;
    assign chain_empty_slot[0] = '0;
    assign chain_max_slot[0]   = '0;
    assign chain_max_rank[0]   = '0;
    assign chain_max_page[0]   = '0;

    always_comb
    begin
        if (frames_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(frames_reg) > FRAMES)
        begin
            n_eff = NW'(FRAMES);
        end
        else
        begin
            n_eff = NW'(frames_reg);
        end
    end

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        lru_pr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .n_in_use       (n_eff),
            .query_page     (page_reg),
            .flags_in       (chain_flags[i]),
            .hit_slot_in    (chain_hit_slot[i]),
            .hit_rank_in    (chain_hit_rank[i]),
            .empty_slot_in  (chain_empty_slot[i]),
            .max_slot_in    (chain_max_slot[i]),
            .max_rank_in    (chain_max_rank[i]),
            .max_page_in    (chain_max_page[i]),
            .flags_out      (chain_flags[i+1]),
            .hit_slot_out   (chain_hit_slot[i+1]),
            .hit_rank_out   (chain_hit_rank[i+1]),
            .empty_slot_out (chain_empty_slot[i+1]),
            .max_slot_out   (chain_max_slot[i+1]),
            .max_rank_out   (chain_max_rank[i+1]),
            .max_page_out   (chain_max_page[i+1]),
            .upd            (upd),
            .upd_slot       (sel_slot),
            .upd_limit      (upd_limit)
        );
    end

    // Result of the search, taken from the far end of the chain.
    assign res_hit      = chain_flags[FRAMES].hit_found;
    assign res_ev_valid = !res_hit && !chain_flags[FRAMES].empty_found;
    assign upd_limit    = res_hit ? chain_hit_rank[FRAMES] : chain_max_rank[FRAMES];

    always_comb
    begin
        if (res_hit)
        begin
            sel_slot = chain_hit_slot[FRAMES];
        end
        else if (chain_flags[FRAMES].empty_found)
        begin
            sel_slot = chain_empty_slot[FRAMES];
        end
        else
        begin
            sel_slot = chain_max_slot[FRAMES];
        end
    end

    assign page_in_wide = {{PAGE_BITS{1'b0}}, req.page};
    assign ev_page_wide = {{PAGE_W{1'b0}}, chain_max_page[FRAMES]};
    assign slot_wide    = {{SLOT_W{1'b0}}, sel_slot};

    always_comb
    begin
        if (res_hit || fault_reg == COUNT_MAX)
        begin
            count_new = fault_reg;
        end
        else
        begin
            count_new = fault_reg + COUNT_W'(1);
        end
    end

    assign req.ready = state_reg == ST_IDLE;
    assign req_xfer  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        upd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SEARCH;
                    cnt_next   = '0;
                end
            end
            ST_SEARCH:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out    = 1'b1;
                    upd.apply   = 1'b1;
                    upd.fault   = !res_hit;
                    upd.age_all = !res_hit && chain_flags[FRAMES].empty_found;
                    upd.clear   = last_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fault_next = fault_reg;
        if (load_out)
        begin
            fault_next = last_reg ? '0 : count_new;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            frames_reg    <= FRAMES_IN_USE_RESET;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                frames_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            page_reg <= page_in_wide[PAGE_BITS-1:0];
            last_reg <= req.last_ref;
        end
        if (load_out)
        begin
            out_hit_reg      <= res_hit;
            out_slot_reg     <= slot_wide[SLOT_W-1:0];
            out_ev_valid_reg <= res_ev_valid;
            out_ev_page_reg  <= res_ev_valid ? ev_page_wide[PAGE_W-1:0] : '0;
            out_count_reg    <= count_new;
            out_last_reg     <= last_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.slot          = out_slot_reg;
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_count   = out_count_reg;
    assign rsp.last_out      = out_last_reg;

endmodule

[hdl/lru_pr_checker.sv]
// Port-level checks for the LRU page replacement unit, bound to its top level.
// Depends on lru_pr_pkg and lru_page_replacement_unit.
module lru_pr_checker import lru_pr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_hit,
    input logic               rsp_evicted_valid,
    input logic [PAGE_W-1:0]  rsp_evicted_page,
    input logic [COUNT_W-1:0] rsp_fault_count
);

    // A response that is not taken stays valid and keeps its evicted page and fault count.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_evicted_page)
                                   && $stable(rsp_fault_count))
        else $error("response changed while stalled");

    // Only one reference is in flight: a request transfer closes the request side.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a reference is in flight");

    // A fault always counts, so its count is never zero.
    a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_fault_count != '0)
        else $error("fault reported with a zero fault count");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> !rsp_evicted_valid)
        else $error("eviction reported on a hit");

    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
        else $error("evicted page nonzero without an eviction");

endmodule

bind lru_page_replacement_unit lru_pr_checker u_lru_pr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_hit           (rsp.hit),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_page  (rsp.evicted_page),
    .rsp_fault_count   (rsp.fault_count)
);

[dv/lru_page_replacement_unit_tb.sv]
// Self-checking testbench for lru_page_replacement_unit: drives page references, predicts
// every response with a behavioral LRU frame table and compares field by field.
// Depends on lru_pr_pkg, the lru_pr channel interfaces and the unit itself.
module lru_page_replacement_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_pr_pkg::*;

    localparam int NFR            = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ALT_REFS       = 24;
    localparam int MAX_PRINTED    = 100;

    typedef struct {
        logic [PAGE_W-1:0] page;
        logic              last;
    } page_ref_t;

    typedef struct {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [COUNT_W-1:0] faults;
        logic               last;
    } lru_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lru_pr_req_if req();
    lru_pr_rsp_if rsp();
    lru_pr_cfg_if cfg();

    lru_page_replacement_unit #(
        .FRAMES   (NFR),
        .PAGE_BITS(PAGE_W)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .cfg  (cfg)
    );

    always #5 clk = ~clk;

    // Behavioral copy of the frame table.
    logic [PAGE_W-1:0]  frame_pg   [NFR];
    bit                 frame_used [NFR];
    int unsigned        frame_age  [NFR];
    logic [COUNT_W-1:0] fault_tally;
    logic [CFG_W-1:0]   frames_cfg;

    page_ref_t   pending_refs [$];
    lru_result_t predicted_results [$];

    bit no_idle;
    int mismatches;
    int stall_cycles;
    int burst_left;
    int gap_left;
    logic [15:0] stall_pat;
    logic [5:0]  pat_pos;

    function void empty_frames();
        for (int i = 0; i < NFR; i++)
        begin
            frame_pg[i]   = '0;
            frame_used[i] = 1'b0;
            frame_age[i]  = 0;
        end
        fault_tally = '0;
    endfunction

    // Slot s becomes the youngest; every valid frame younger than limit ages by one.
    function void make_newest(int s, int unsigned limit);
        for (int i = 0; i < NFR; i++)
        begin
            if (i != s && frame_used[i] && frame_age[i] < limit)
                frame_age[i]++;
        end
        frame_age[s] = 0;
    endfunction

    function lru_result_t lookup_page(logic [PAGE_W-1:0] pg, logic last);
        lru_result_t r;
        int n;
        int s;
        bit found;
        bit got_empty;
        int unsigned oldest;
        r.ev_valid = 1'b0;
        r.ev_page  = '0;
        n = int'(frames_cfg);
        if (n < 1)
            n = 1;
        if (n > NFR)
            n = NFR;
        found     = 1'b0;
        got_empty = 1'b0;
        s         = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && frame_used[i] && frame_pg[i] == pg)
            begin
                found = 1'b1;
                s     = i;
            end
        end
        if (found)
            make_newest(s, frame_age[s]);
        else
        begin
            // The highest-numbered empty frame wins.
            for (int i = 0; i < n; i++)
            begin
                if (!frame_used[i])
                begin
                    s         = i;
                    got_empty = 1'b1;
                end
            end
            if (got_empty)
            begin
                make_newest(s, 255);
                frame_used[s] = 1'b1;
            end
            else
            begin
                oldest = 0;
                s      = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (frame_age[i] > oldest)
                    begin
                        oldest = frame_age[i];
                        s      = i;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = frame_pg[s];
                make_newest(s, frame_age[s]);
            end
            frame_pg[s] = pg;
            if (fault_tally != COUNT_MAX)
                fault_tally++;
        end
        r.hit    = found;
        r.slot   = SLOT_W'(s);
        r.faults = fault_tally;
        r.last   = last;
        if (last)
            empty_frames();
        return r;
    endfunction

    task report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    // Request driver: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        page_ref_t nxt;
        if (!rst_n)
        begin
            req.valid    <= 1'b0;
            req.page     <= '0;
            req.last_ref <= 1'b0;
            burst_left   <= 1;
            gap_left     <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (!no_idle && gap_left > 0)
            begin
                gap_left  <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_refs.size() > 0)
            begin
                nxt = pending_refs.pop_front();
                req.valid    <= 1'b1;
                req.page     <= nxt.page;
                req.last_ref <= nxt.last;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Response stalls follow a 16-bit pattern, redrawn when pat_pos wraps. Bit zero is
    // always set so that no stall outlasts one pass through the pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_pat <= '1;
            pat_pos   <= '0;
        end
        else
        begin
            pat_pos <= pat_pos + 1'b1;
            if (pat_pos == 6'd63)
                stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
            rsp.ready <= no_idle || stall_pat[pat_pos[3:0]];
        end
    end

    // Monitor: predicts on each request transfer, checks each response transfer.
    always @(posedge clk)
    begin
        lru_result_t want;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                frames_cfg = cfg.data;
            if (req.valid && req.ready)
                predicted_results.push_back(lookup_page(req.page, req.last_ref));
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("unexpected response, slot", rsp.slot, 0);
                else
                begin
                    want = predicted_results.pop_front();
                    if (rsp.hit !== want.hit)
                        report_mismatch("hit", rsp.hit, want.hit);
                    if (rsp.slot !== want.slot)
                        report_mismatch("slot", rsp.slot, want.slot);
                    if (rsp.evicted_valid !== want.ev_valid)
                        report_mismatch("evicted_valid", rsp.evicted_valid, want.ev_valid);
                    if (rsp.evicted_page !== want.ev_page)
                        report_mismatch("evicted_page", rsp.evicted_page, want.ev_page);
                    if (rsp.fault_count !== want.faults)
                        report_mismatch("fault_count", rsp.fault_count, want.faults);
                    if (rsp.last_out !== want.last)
                        report_mismatch("last_out", rsp.last_out, want.last);
                end
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task queue_ref(input logic [PAGE_W-1:0] pg, input logic last);
        page_ref_t r;
        r.page = pg;
        r.last = last;
        pending_refs.push_back(r);
    endtask

    function logic [PAGE_W-1:0] fresh_page();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PAGE_W'($urandom);
        endcase
    endfunction

    // Reference strings drawn mostly from a small working set, with some strays,
    // some new pages and the occasional early end of string.
    task automatic queue_strings(input int total, input bit close_last);
        logic [PAGE_W-1:0] hot [$];
        logic [PAGE_W-1:0] pg;
        int str_len;
        int roll;
        bit ends;
        while (total > 0)
        begin
            str_len = $urandom_range(1, 48);
            if (str_len > total)
                str_len = total;
            hot.delete();
            repeat ($urandom_range(1, 20))
                hot.push_back(fresh_page());
            for (int k = 0; k < str_len; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    pg = hot[$urandom_range(0, hot.size() - 1)];
                else if (roll < 85)
                    pg = PAGE_W'($urandom);
                else
                begin
                    pg = fresh_page();
                    hot.push_back(pg);
                end
                ends = (k == str_len - 1) && (total > str_len || close_last);
                queue_ref(pg, ends || ($urandom_range(0, 99) == 0));
            end
            total -= str_len;
        end
    endtask

    task write_frames(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Sender holds off until every predicted response has been checked.
    task wait_idle();
        do
            @(negedge clk);
        while (pending_refs.size() != 0 || req.valid || predicted_results.size() != 0);
        repeat (NFR + 4) @(negedge clk);
    endtask

    initial
    begin
        logic [CFG_W-1:0] setting;
        rst_n        = 1'b0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        no_idle      = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        empty_frames();
        frames_cfg = FRAMES_IN_USE_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Four frames: fill from the top, hits, then LRU evictions.
        write_frames(5'd4);
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'hFFFF, 1'b0);
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'h0001, 1'b0);
        queue_ref(16'h0002, 1'b0);
        queue_ref(16'h0003, 1'b0);
        queue_ref(16'hFFFF, 1'b0);
        queue_ref(16'h0001, 1'b0);
        queue_ref(16'h8000, 1'b0);
        wait_idle();

        // Shrink mid-string: upper frames keep their pages but are not searched.
        write_frames(5'd2);
        queue_ref(16'h0001, 1'b0);
        queue_ref(16'h0003, 1'b0);
        queue_ref(16'h5555, 1'b0);
        queue_ref(16'hAAAA, 1'b0);
        queue_ref(16'h0001, 1'b1);
        wait_idle();

        // A count of zero behaves as one frame.
        write_frames(5'd0);
        queue_ref(16'h1234, 1'b0);
        queue_ref(16'h1234, 1'b0);
        queue_ref(16'h4321, 1'b0);
        queue_ref(16'hFFFF, 1'b1);
        wait_idle();

        // A count above the frame total behaves as all frames.
        write_frames(5'd31);
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'h0000, 1'b0);
        queue_ref(16'h7FFF, 1'b1);
        queue_ref(16'hBEEF, 1'b1);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0:       setting = 5'd16;
                1:       setting = 5'd1;
                2:       setting = 5'd31;
                3:       setting = 5'd0;
                4:       setting = 5'd17;
                default: setting = CFG_W'($urandom_range(0, 31));
            endcase
            write_frames(setting);
            queue_strings(85, $urandom_range(0, 2) != 0);
            wait_idle();
        end

        // One frame and two alternating pages fault on every reference, with the
        // sender and the receiver never idle.
        write_frames(5'd1);
        no_idle = 1'b1;
        for (int i = 0; i < ALT_REFS; i++)
            queue_ref((i % 2 == 0) ? 16'h5A5A : 16'hA5A5, i == ALT_REFS - 1);
        wait_idle();
        no_idle = 1'b0;
        queue_strings(20, 1'b1);
        wait_idle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
